### rtl/lsact_pkg.sv
`default_nettype none
package lsact_pkg;
  localparam int unsigned LOG_ROWS_DEFAULT = 10;
  localparam int unsigned WAYS_DEFAULT = 4;
  localparam int unsigned CNT_W = 48;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_SHIFT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_SHIFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_PHYS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED = 3'd4;

  localparam logic [1:0] MODE_VV = 2'd0;
  localparam logic [1:0] MODE_VP = 2'd1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] addr;
  } req_t;

  typedef struct packed {
    logic            hit;
    logic [1:0]      way_used;
    logic [9:0]      row_index;
    logic [31:0]     line_tag;
    logic            evicted_valid;
    logic [CNT_W-1:0] read_total;
    logic [CNT_W-1:0] write_total;
    logic [CNT_W-1:0] read_hit_total;
    logic [CNT_W-1:0] write_hit_total;
  } rsp_t;

  function automatic logic [31:0] sar(input logic [31:0] v, input int unsigned n);
    sar = $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] hash_a(input logic [31:0] a);
    logic [31:0] k;
    k = ~a + (a << 15);
    k = k ^ sar(k, 12);
    k = k + (k << 2);
    k = k ^ sar(k, 4);
    hash_a = k;
  endfunction

  function automatic logic [31:0] hash_b(input logic [31:0] a, input logic [5:0] lps);
    logic [31:0] k;
    logic [31:0] m;
    k = a ^ sar(a, 16);
    if (lps == 6'd0) m = 32'd0;
    else if (lps >= 6'd32) m = '1;
    else m = 32'hFFFF_FFFF >> (6'd32 - lps);
    hash_b = k & m;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (&c) ? c : c + 1'b1;
  endfunction
endpackage
`default_nettype wire

### rtl/lsact_if.sv
`default_nettype none
interface lsact_req_if;
  logic valid;
  logic ready;
  lsact_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface lsact_rsp_if;
  logic valid;
  logic ready;
  lsact_pkg::rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/lru_set_assoc_cache_tags.sv
// Flow: IDLE accepts a request and hashes it, MUL registers its row and tag, READ
// reads the row, and UPD writes the row back and registers the response. Requests
// are not overlapped (hash stage, multiply stage, memory read, read-modify-write
// of the row, response handoff): the next request waits for the row write-back
// and for the previous response to be taken. Reset: synchronous rst clears
// control, registers to reset values, counters to zero, and then sweeps all rows
// clearing valid and LRU, one row per cycle, during which no request is accepted.
`default_nettype none
module lru_set_assoc_cache_tags #(
  parameter int unsigned LOG_ROWS = lsact_pkg::LOG_ROWS_DEFAULT,
  parameter int unsigned WAYS = lsact_pkg::WAYS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  lsact_req_if.sink   req,
  lsact_rsp_if.source rsp,
  input  wire logic cfg_we,
  input  wire logic [lsact_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lsact_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int unsigned ROWS = 1 << LOG_ROWS;
  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned NW = $clog2(WAYS + 1);
  localparam int unsigned CW = lsact_pkg::CNT_W;

  typedef logic [WW-1:0] way_t;
  typedef struct packed {
    logic [WAYS-1:0]       valid;
    logic [WAYS-1:0][31:0] tags;
    way_t [WAYS-1:0]       order;
  } row_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001, S_IDLE = 5'b00010, S_MUL = 5'b00100,
    S_READ = 5'b01000, S_UPD = 5'b10000
  } state_t;

  state_t state;
  logic [LOG_ROWS-1:0] clr_row;
  logic [1:0] addr_mode;
  logic [4:0] index_shift, tag_shift;
  logic [5:0] log_phys_size;
  logic [2:0] ways_used;
  logic is_write;
  logic [31:0] va, ka, pa;
  logic [LOG_ROWS-1:0] row;
  logic [31:0] tag;
  logic [CW-1:0] rd_cnt, wr_cnt, rdh_cnt, wrh_cnt;
  row_t mem [ROWS];
  row_t rdata, wdata, init_row;
  logic mem_we;
  logic [LOG_ROWS-1:0] mem_addr;
  logic [NW-1:0] n_ways;
  logic hit_c, evict_c;
  way_t way_c;
  lsact_pkg::rsp_t out_r;
  logic out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_mode <= '0; index_shift <= 5'd17; tag_shift <= 5'd15;
      log_phys_size <= 6'd16; ways_used <= 3'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        lsact_pkg::CFG_ADDR_MODE: addr_mode <= cfg_data[1:0];
        lsact_pkg::CFG_INDEX_SHIFT: index_shift <= cfg_data[4:0];
        lsact_pkg::CFG_TAG_SHIFT: tag_shift <= cfg_data[4:0];
        lsact_pkg::CFG_LOG_PHYS: log_phys_size <= cfg_data[5:0];
        lsact_pkg::CFG_WAYS_USED: ways_used <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    init_row = '0;
    for (int i = 0; i < WAYS; i++) init_row.order[i] = way_t'(i);
    if (ways_used == 3'd0) n_ways = NW'(1);
    else if (32'(ways_used) > WAYS) n_ways = NW'(WAYS);
    else n_ways = NW'(ways_used);
  end

  assign pa = lsact_pkg::hash_b(ka * 32'd2057, log_phys_size);

  always_comb begin
    hit_c = 1'b0;
    way_c = '0;
    for (int w = WAYS - 1; w >= 0; w--)
      if (32'(w) < 32'(n_ways) && rdata.valid[w] && rdata.tags[w] == tag) begin
        hit_c = 1'b1; way_c = way_t'(w);
      end
    if (!hit_c)
      for (int p = 0; p < WAYS; p++)
        if (32'(rdata.order[p]) < 32'(n_ways)) way_c = rdata.order[p];
    evict_c = !hit_c && rdata.valid[way_c];
    wdata = rdata;
    if (!hit_c) begin
      wdata.valid[way_c] = 1'b1;
      wdata.tags[way_c] = tag;
    end
    begin
      logic found;
      found = 1'b0;
      for (int p = WAYS - 1; p > 0; p--) begin
        found = found | (rdata.order[p] == way_c);
        if (found) wdata.order[p] = rdata.order[p-1];
      end
      wdata.order[0] = way_c;
    end
  end

  assign mem_we = (state == S_CLEAR) || (state == S_UPD);
  assign mem_addr = (state == S_CLEAR) ? clr_row : row;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= (state == S_CLEAR) ? init_row : wdata;
    rdata <= mem[mem_addr];
  end

  assign req.ready = (state == S_IDLE) && !out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_row <= '0; out_v <= 1'b0;
      rd_cnt <= '0; wr_cnt <= '0; rdh_cnt <= '0; wrh_cnt <= '0;
    end else begin
      if (out_v && rsp.ready) out_v <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (&clr_row) state <= S_IDLE;
        end
        S_IDLE: if (req.valid && req.ready) begin
          is_write <= req.data.req_type;
          va <= {req.data.addr[31:2], 2'b00};
          ka <= lsact_pkg::hash_a({req.data.addr[31:2], 2'b00});
          state <= S_MUL;
        end
        S_MUL: begin
          row <= LOG_ROWS'(((addr_mode[1]) ? pa : va) >> index_shift);
          tag <= ((addr_mode == lsact_pkg::MODE_VV) ? va : pa) >> tag_shift;
          state <= S_READ;
        end
        S_READ: state <= S_UPD;
        S_UPD: begin
          out_v <= 1'b1;
          out_r.hit <= hit_c;
          out_r.way_used <= 2'(way_c);
          out_r.row_index <= 10'(row);
          out_r.line_tag <= tag;
          out_r.evicted_valid <= evict_c;
          if (is_write) begin
            wr_cnt <= lsact_pkg::sat_inc(wr_cnt);
            out_r.write_total <= lsact_pkg::sat_inc(wr_cnt);
            out_r.read_total <= rd_cnt;
            out_r.read_hit_total <= rdh_cnt;
            if (hit_c) wrh_cnt <= lsact_pkg::sat_inc(wrh_cnt);
            out_r.write_hit_total <= hit_c ? lsact_pkg::sat_inc(wrh_cnt) : wrh_cnt;
          end else begin
            rd_cnt <= lsact_pkg::sat_inc(rd_cnt);
            out_r.read_total <= lsact_pkg::sat_inc(rd_cnt);
            out_r.write_total <= wr_cnt;
            out_r.write_hit_total <= wrh_cnt;
            if (hit_c) rdh_cnt <= lsact_pkg::sat_inc(rdh_cnt);
            out_r.read_hit_total <= hit_c ? lsact_pkg::sat_inc(rdh_cnt) : rdh_cnt;
          end
          state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  assign rsp.valid = out_v;
  assign rsp.data = out_r;
endmodule
`default_nettype wire
